### design/axis_angle_vector_rotation_top_assert.svh
// Assertion macros for the axis-angle rotation block.
`ifndef AXIS_ANGLE_VECTOR_ROTATION_TOP_ASSERT_SVH
`define AXIS_ANGLE_VECTOR_ROTATION_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AVR_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("avr: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define AVR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("avr: next-cycle check failed");

`endif

### design/avr_pkg.sv
// ----------------------------------------------------------------------------
// avr_pkg
// Shared widths, register indexes, constants and types of the axis-angle
// vector rotation block.
// ----------------------------------------------------------------------------
package avr_pkg;

  localparam int COORD_W      = 32;
  localparam int ANGLE_W      = 32;
  localparam int CFG_W        = (COORD_W > 32) ? COORD_W : 32;
  localparam int CFG_IDX_W    = 3;
  localparam int FRAC         = 30;
  localparam int ENTRY_W      = 34;
  localparam int CORDIC_STEPS = 30;
  localparam int ZW           = 33;
  localparam int MUL_W        = 35;

  localparam logic [CFG_IDX_W-1:0] REG_AXIS_MODE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROTATION_ANGLE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_X         = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_Y         = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_Z         = 3'd4;

  localparam logic [1:0] MODE_X   = 2'd0;
  localparam logic [1:0] MODE_Y   = 2'd1;
  localparam logic [1:0] MODE_Z   = 2'd2;
  localparam logic [1:0] MODE_ARB = 2'd3;

  typedef logic signed [ENTRY_W-1:0] entry_t;

  localparam entry_t ONE_Q30     = ENTRY_W'(64'sd1 <<< FRAC);
  localparam entry_t CORDIC_GAIN = ENTRY_W'(64'sd652032874);

  typedef struct packed {
    logic             busy;
    logic             err;
    entry_t [8:0]     e;
  } matrix_t;

  // CORDIC arctangent table in binary angle units (full turn is 2^32).
  function automatic logic [ZW-1:0] atan_turn(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000029;
      5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A;
      5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000003;
      5'd29: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return ZW'(v);
  endfunction

endpackage

### design/avr_in_if.sv
// ----------------------------------------------------------------------------
// avr_in_if
// Input vector channel: valid/ready handshake with op and vector payload.
// ----------------------------------------------------------------------------
interface avr_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 op;
  logic signed [avr_pkg::COORD_W-1:0]   vec_x;
  logic signed [avr_pkg::COORD_W-1:0]   vec_y;
  logic signed [avr_pkg::COORD_W-1:0]   vec_z;

  modport source (output valid, output op, output vec_x, output vec_y, output vec_z,
                  input ready);
  modport sink   (input valid, input op, input vec_x, input vec_y, input vec_z,
                  output ready);
endinterface

### design/avr_out_if.sv
// ----------------------------------------------------------------------------
// avr_out_if
// Result channel: valid/ready handshake with rotated vector and error flag.
// ----------------------------------------------------------------------------
interface avr_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [avr_pkg::COORD_W-1:0]   out_x;
  logic signed [avr_pkg::COORD_W-1:0]   out_y;
  logic signed [avr_pkg::COORD_W-1:0]   out_z;
  logic                                 axis_error;

  modport source (output valid, output out_x, output out_y, output out_z,
                  output axis_error, input ready);
  modport sink   (input valid, input out_x, input out_y, input out_z,
                  input axis_error, output ready);
endinterface

### design/avr_matrix.sv
// ----------------------------------------------------------------------------
// avr_matrix
// Configuration registers and the sequencer that rebuilds the rotation
// matrix: CORDIC, axis normalisation, square root, division and products.
// ----------------------------------------------------------------------------
module avr_matrix (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [avr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [avr_pkg::CFG_W-1:0]       cfg_data,
  output avr_pkg::matrix_t                mat
);

  localparam int CW = avr_pkg::COORD_W;
  localparam int MW = (CW > 32) ? CW : 32;
  localparam int PW = 2 * avr_pkg::MUL_W;

  typedef enum logic [3:0] {
    ST_INIT, ST_CORDIC, ST_NORM, ST_SQUARE, ST_SQRT, ST_DIV, ST_PROD, ST_FINISH, ST_IDLE
  } state_t;

  state_t                             state;
  logic [1:0]                         axis_mode;
  logic [31:0]                        rotation_angle;
  logic [CW-1:0]                      axis_x, axis_y, axis_z;
  logic [5:0]                         cnt;
  logic                               phase;
  logic [1:0]                         ci;
  logic                               neg;
  avr_pkg::entry_t                    cx, cy;
  logic signed [avr_pkg::ZW-1:0]      cz;
  logic [MW-1:0]                      mag [3];
  logic [2:0]                         sgn;
  logic [63:0]                        sq_n, sq_r, sq_b;
  logic [33:0]                        rem;
  logic [30:0]                        quo;
  logic signed [31:0]                 u [3];
  avr_pkg::entry_t                    t [15];
  logic signed [avr_pkg::MUL_W-1:0]   mul_a, mul_b;
  logic signed [PW-1:0]               prod;
  logic                               err;
  avr_pkg::entry_t                    e [9];

  // Combinational helpers.
  logic [31:0]                        a_raw, a_fold;
  logic                               a_neg;
  avr_pkg::entry_t                    dx, dy, cs, sn, m;
  logic [avr_pkg::ZW-1:0]             atan;
  logic [MW-1:0]                      mx, mx_hi;
  logic [MW-1:0]                      mag_abs [3];
  logic                               mx_low, mx_over;
  logic [65:0]                        rb;
  logic [33:0]                        r2;
  logic                               qb;
  logic [30:0]                        quo_next;
  logic [MW-1:0]                      mag_div;
  avr_pkg::entry_t                    mulq;

  always_comb begin
    a_raw  = 32'(rotation_angle[avr_pkg::ANGLE_W-1:0]) << (32 - avr_pkg::ANGLE_W);
    a_neg  = (a_raw[31:30] == 2'b01) || (a_raw[31:30] == 2'b10);
    a_fold = a_neg ? (a_raw ^ 32'h8000_0000) : a_raw;
    dx     = cy >>> cnt[4:0];
    dy     = cx >>> cnt[4:0];
    atan   = avr_pkg::atan_turn(cnt[4:0]);
    cs     = neg ? -cx : cx;
    sn     = neg ? -cy : cy;
    m      = avr_pkg::ONE_Q30 - cs;
    mag_abs[0] = MW'(axis_x[CW-1] ? (~axis_x + 1'b1) : axis_x);
    mag_abs[1] = MW'(axis_y[CW-1] ? (~axis_y + 1'b1) : axis_y);
    mag_abs[2] = MW'(axis_z[CW-1] ? (~axis_z + 1'b1) : axis_z);
    mx = (mag[0] > mag[1]) ? mag[0] : mag[1];
    if (mag[2] > mx) begin
      mx = mag[2];
    end
    mx_hi   = mx >> 31;
    mx_low  = (mx >> 30) == '0;
    mx_over = (mx_hi > MW'(1)) || ((mx_hi == MW'(1)) && (mx[30:0] != '0));
    rb      = {2'b00, sq_r} + {2'b00, sq_b};
    mag_div = mag[ci];
    r2      = {rem[32:0], (cnt == 6'd0) ? mag_div[0] : 1'b0};
    qb      = r2 >= {1'b0, sq_r[32:0]};
    quo_next = {quo[29:0], qb};
    mulq    = prod[avr_pkg::FRAC+avr_pkg::ENTRY_W-1:avr_pkg::FRAC];
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state == ST_SQUARE) begin
      case (cnt[1:0])
        2'd0:    mul_a = avr_pkg::MUL_W'({1'b0, mag[0][31:0]});
        2'd1:    mul_a = avr_pkg::MUL_W'({1'b0, mag[1][31:0]});
        default: mul_a = avr_pkg::MUL_W'({1'b0, mag[2][31:0]});
      endcase
      mul_b = mul_a;
    end else begin
      case (cnt[3:0])
        4'd0:  begin mul_a = avr_pkg::MUL_W'(u[0]); mul_b = avr_pkg::MUL_W'(u[0]); end
        4'd1:  begin mul_a = avr_pkg::MUL_W'(u[0]); mul_b = avr_pkg::MUL_W'(u[1]); end
        4'd2:  begin mul_a = avr_pkg::MUL_W'(u[0]); mul_b = avr_pkg::MUL_W'(u[2]); end
        4'd3:  begin mul_a = avr_pkg::MUL_W'(u[1]); mul_b = avr_pkg::MUL_W'(u[1]); end
        4'd4:  begin mul_a = avr_pkg::MUL_W'(u[1]); mul_b = avr_pkg::MUL_W'(u[2]); end
        4'd5:  begin mul_a = avr_pkg::MUL_W'(u[2]); mul_b = avr_pkg::MUL_W'(u[2]); end
        4'd6:  begin mul_a = avr_pkg::MUL_W'(t[0]); mul_b = avr_pkg::MUL_W'(m); end
        4'd7:  begin mul_a = avr_pkg::MUL_W'(t[1]); mul_b = avr_pkg::MUL_W'(m); end
        4'd8:  begin mul_a = avr_pkg::MUL_W'(t[2]); mul_b = avr_pkg::MUL_W'(m); end
        4'd9:  begin mul_a = avr_pkg::MUL_W'(t[3]); mul_b = avr_pkg::MUL_W'(m); end
        4'd10: begin mul_a = avr_pkg::MUL_W'(t[4]); mul_b = avr_pkg::MUL_W'(m); end
        4'd11: begin mul_a = avr_pkg::MUL_W'(t[5]); mul_b = avr_pkg::MUL_W'(m); end
        4'd12: begin mul_a = avr_pkg::MUL_W'(u[0]); mul_b = avr_pkg::MUL_W'(sn); end
        4'd13: begin mul_a = avr_pkg::MUL_W'(u[1]); mul_b = avr_pkg::MUL_W'(sn); end
        4'd14: begin mul_a = avr_pkg::MUL_W'(u[2]); mul_b = avr_pkg::MUL_W'(sn); end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_INIT;
      axis_mode      <= avr_pkg::MODE_Z;
      rotation_angle <= '0;
      axis_x         <= '0;
      axis_y         <= '0;
      axis_z         <= CW'(65536);
      err            <= 1'b0;
      cnt            <= '0;
      phase          <= 1'b0;
      ci             <= '0;
    end else if (cfg_we) begin
      // Any write restarts the matrix build from the new register values.
      case (cfg_index)
        avr_pkg::REG_AXIS_MODE:      axis_mode      <= cfg_data[1:0];
        avr_pkg::REG_ROTATION_ANGLE: rotation_angle <= cfg_data[31:0];
        avr_pkg::REG_AXIS_X:         axis_x         <= cfg_data[CW-1:0];
        avr_pkg::REG_AXIS_Y:         axis_y         <= cfg_data[CW-1:0];
        avr_pkg::REG_AXIS_Z:         axis_z         <= cfg_data[CW-1:0];
        default: ;
      endcase
      state <= ST_INIT;
    end else begin
      case (state)
        ST_INIT: begin
          cx    <= avr_pkg::CORDIC_GAIN;
          cy    <= '0;
          cz    <= avr_pkg::ZW'($signed(a_fold));
          neg   <= a_neg;
          mag   <= mag_abs;
          sgn   <= {axis_z[CW-1], axis_y[CW-1], axis_x[CW-1]};
          err   <= 1'b0;
          cnt   <= '0;
          state <= ST_CORDIC;
        end
        ST_CORDIC: begin
          if (!cz[avr_pkg::ZW-1]) begin
            cx <= cx - dx;
            cy <= cy + dy;
            cz <= cz - $signed(atan);
          end else begin
            cx <= cx + dx;
            cy <= cy - dy;
            cz <= cz + $signed(atan);
          end
          cnt <= cnt + 6'd1;
          if (cnt == 6'(avr_pkg::CORDIC_STEPS - 1)) begin
            if (axis_mode != avr_pkg::MODE_ARB) begin
              state <= ST_FINISH;
            end else if (mx == '0) begin
              err   <= 1'b1;
              state <= ST_FINISH;
            end else begin
              state <= ST_NORM;
            end
          end
        end
        ST_NORM: begin
          if (mx_low) begin
            for (int i = 0; i < 3; i++) mag[i] <= mag[i] << 1;
          end else if (mx_over) begin
            for (int i = 0; i < 3; i++) mag[i] <= mag[i] >> 1;
          end else begin
            sq_n  <= '0;
            cnt   <= '0;
            phase <= 1'b0;
            state <= ST_SQUARE;
          end
        end
        ST_SQUARE: begin
          phase <= ~phase;
          if (phase) begin
            sq_n <= sq_n + prod[63:0];
            cnt  <= cnt + 6'd1;
            if (cnt == 6'd2) begin
              sq_r  <= '0;
              sq_b  <= 64'd1 << 62;
              cnt   <= '0;
              state <= ST_SQRT;
            end
          end
        end
        ST_SQRT: begin
          if ({2'b00, sq_n} >= rb) begin
            sq_n <= sq_n - rb[63:0];
            sq_r <= (sq_r >> 1) + sq_b;
          end else begin
            sq_r <= sq_r >> 1;
          end
          sq_b <= sq_b >> 2;
          cnt  <= cnt + 6'd1;
          if (cnt == 6'd31) begin
            ci    <= '0;
            phase <= 1'b0;
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (!phase) begin
            rem   <= 34'(mag_div[31:1]);
            quo   <= '0;
            cnt   <= '0;
            phase <= 1'b1;
          end else begin
            rem <= qb ? (r2 - {1'b0, sq_r[32:0]}) : r2;
            quo <= quo_next;
            cnt <= cnt + 6'd1;
            if (cnt == 6'd30) begin
              u[ci] <= sgn[ci] ? -$signed(32'(quo_next)) : $signed(32'(quo_next));
              phase <= 1'b0;
              if (ci == 2'd2) begin
                cnt   <= '0;
                state <= ST_PROD;
              end else begin
                ci <= ci + 2'd1;
              end
            end
          end
        end
        ST_PROD: begin
          phase <= ~phase;
          if (phase) begin
            t[cnt[3:0]] <= mulq;
            cnt         <= cnt + 6'd1;
            if (cnt == 6'd14) begin
              state <= ST_FINISH;
            end
          end
        end
        ST_FINISH: begin
          case (axis_mode)
            avr_pkg::MODE_X: begin
              e[0] <= avr_pkg::ONE_Q30; e[1] <= '0; e[2] <= '0;
              e[3] <= '0; e[4] <= cs; e[5] <= -sn;
              e[6] <= '0; e[7] <= sn; e[8] <= cs;
            end
            avr_pkg::MODE_Y: begin
              e[0] <= cs; e[1] <= '0; e[2] <= sn;
              e[3] <= '0; e[4] <= avr_pkg::ONE_Q30; e[5] <= '0;
              e[6] <= -sn; e[7] <= '0; e[8] <= cs;
            end
            avr_pkg::MODE_Z: begin
              e[0] <= cs; e[1] <= -sn; e[2] <= '0;
              e[3] <= sn; e[4] <= cs; e[5] <= '0;
              e[6] <= '0; e[7] <= '0; e[8] <= avr_pkg::ONE_Q30;
            end
            default: begin
              // Transposed Rodrigues form: t[6..11] hold uu*m, t[12..14] hold u*s.
              e[0] <= cs + t[6];
              e[1] <= t[7] + t[14];
              e[2] <= t[8] - t[13];
              e[3] <= t[7] - t[14];
              e[4] <= cs + t[9];
              e[5] <= t[10] + t[12];
              e[6] <= t[8] + t[13];
              e[7] <= t[10] - t[12];
              e[8] <= cs + t[11];
            end
          endcase
          state <= ST_IDLE;
        end
        ST_IDLE: ;
        default: state <= ST_INIT;
      endcase
    end
  end

  always_comb begin
    mat.busy = (state != ST_IDLE);
    mat.err  = err;
    for (int i = 0; i < 9; i++) mat.e[i] = e[i];
  end

endmodule

### design/axis_angle_vector_rotation_top.sv
// Throughput: one vector per cycle through a four-stage multiply pipeline
// while the output is ready and no matrix rebuild is running.
// After reset and after every configuration write the matrix is rebuilt by a
// sequencer (CORDIC alone for x, y or z axes; an arbitrary axis adds
// normalisation, square root, three divisions and fifteen products) and no
// input transaction is accepted until it completes.
// ----------------------------------------------------------------------------
// axis_angle_vector_rotation_top
// Rotates a stream of fixed-point 3D vectors by a configured rotation matrix
// or its transpose, with saturation of the results.
// ----------------------------------------------------------------------------
`include "axis_angle_vector_rotation_top_assert.svh"

module axis_angle_vector_rotation_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [avr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [avr_pkg::CFG_W-1:0]       cfg_data,
  avr_in_if.sink                          vec_in,
  avr_out_if.source                       vec_out
);

  localparam int CW     = avr_pkg::COORD_W;
  localparam int PROD_W = avr_pkg::ENTRY_W + CW;
  localparam int SUM_W  = PROD_W + 2;
  localparam int SH_W   = SUM_W - avr_pkg::FRAC;
  localparam logic signed [SH_W-1:0] SAT_MAX = SH_W'((64'sd1 <<< (CW - 1)) - 64'sd1);
  localparam logic signed [SH_W-1:0] SAT_MIN = -SAT_MAX - SH_W'(1);

  avr_pkg::matrix_t           mat;

  logic                       s1_v, s2_v, s3_v;
  logic                       s1_err, s2_err, s3_err;
  avr_pkg::entry_t            s1_e [9];
  logic signed [CW-1:0]       s1_vec [3];
  logic signed [PROD_W-1:0]   s2_p [9];
  logic signed [SUM_W-1:0]    s3_s [3];
  avr_pkg::entry_t            e_sel [9];
  logic signed [SH_W-1:0]     sh [3];
  logic signed [CW-1:0]       sat [3];
  logic                       free1, free2, free3, free4;

  avr_matrix u_matrix (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .mat       (mat)
  );

  // Each stage loads when it is empty or its content moves on this cycle.
  assign free4 = !vec_out.valid || vec_out.ready;
  assign free3 = !s3_v || free4;
  assign free2 = !s2_v || free3;
  assign free1 = !s1_v || free2;
  assign vec_in.ready = free1 && !mat.busy;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        e_sel[i*3+k] = vec_in.op ? $signed(mat.e[k*3+i]) : $signed(mat.e[i*3+k]);
      end
    end
    for (int i = 0; i < 3; i++) begin
      sh[i] = $signed(s3_s[i][SUM_W-1:avr_pkg::FRAC]);
      if (sh[i] > SAT_MAX) begin
        sat[i] = SAT_MAX[CW-1:0];
      end else if (sh[i] < SAT_MIN) begin
        sat[i] = SAT_MIN[CW-1:0];
      end else begin
        sat[i] = sh[i][CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v          <= 1'b0;
      s2_v          <= 1'b0;
      s3_v          <= 1'b0;
      vec_out.valid <= 1'b0;
    end else begin
      if (free1) s1_v <= vec_in.valid && vec_in.ready;
      if (free2) s2_v <= s1_v;
      if (free3) s3_v <= s2_v;
      if (free4) vec_out.valid <= s3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (free1) begin
      s1_e      <= e_sel;
      s1_vec[0] <= vec_in.vec_x;
      s1_vec[1] <= vec_in.vec_y;
      s1_vec[2] <= vec_in.vec_z;
      s1_err    <= mat.err;
    end
    if (free2) begin
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < 3; k++) begin
          s2_p[i*3+k] <= s1_e[i*3+k] * s1_vec[k];
        end
      end
      s2_err <= s1_err;
    end
    if (free3) begin
      for (int i = 0; i < 3; i++) begin
        s3_s[i] <= SUM_W'(s2_p[i*3]) + SUM_W'(s2_p[i*3+1]) + SUM_W'(s2_p[i*3+2]);
      end
      s3_err <= s2_err;
    end
    if (free4) begin
      vec_out.out_x      <= s3_err ? '0 : sat[0];
      vec_out.out_y      <= s3_err ? '0 : sat[1];
      vec_out.out_z      <= s3_err ? '0 : sat[2];
      vec_out.axis_error <= s3_err;
    end
  end

  `AVR_ASSERT_NEXT(a_cfg_restarts_build, clk, rst, cfg_we, mat.busy)
  `AVR_ASSERT_SAME(a_no_accept_while_busy, clk, rst, vec_in.valid && vec_in.ready, !mat.busy)
  `AVR_ASSERT_SAME(a_error_gives_zero, clk, rst, vec_out.valid && vec_out.axis_error, (vec_out.out_x == '0) && (vec_out.out_y == '0) && (vec_out.out_z == '0))

endmodule

### bench/axis_angle_vector_rotation_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// axis_angle_vector_rotation_top_tb
// Streams vectors through the rotation block under a series of axis and
// angle settings, predicts every rotated vector bit for bit and compares it
// with the block's output, both channels idling at random in most phases.
// ----------------------------------------------------------------------------
module axis_angle_vector_rotation_top_tb;

  typedef struct {
    logic                               op;
    logic signed [avr_pkg::COORD_W-1:0] x;
    logic signed [avr_pkg::COORD_W-1:0] y;
    logic signed [avr_pkg::COORD_W-1:0] z;
  } vec_item_t;

  typedef struct {
    logic signed [avr_pkg::COORD_W-1:0] x;
    logic signed [avr_pkg::COORD_W-1:0] y;
    logic signed [avr_pkg::COORD_W-1:0] z;
    logic                               err;
  } rot_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [avr_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [avr_pkg::CFG_W-1:0] cfg_data = '0;

  avr_in_if  vin();
  avr_out_if vout();

  axis_angle_vector_rotation_top dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .vec_in(vin.sink), .vec_out(vout.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Local copy of the configuration registers.
  logic [1:0]  cur_mode  = avr_pkg::MODE_Z;
  logic [31:0] cur_angle = '0;
  logic [31:0] cur_ax = '0, cur_ay = '0, cur_az = 32'd65536;

  longint atan_tbl [0:29];
  vec_item_t pending_vecs[$];
  rot_res_t  expected_rots[$];
  int mismatches = 0;
  bit idle_on = 1'b1;

  function automatic longint mulq(longint a, longint b);
    return (a * b) >>> 30;
  endfunction

  function automatic longint unsigned isqrt(longint unsigned n);
    longint unsigned root, sq_bit;
    root = 0;
    sq_bit = 64'd1 << 62;
    while (sq_bit > n) sq_bit = sq_bit >> 2;
    while (sq_bit != 0) begin
      if (n >= root + sq_bit) begin
        n = n - (root + sq_bit);
        root = (root >> 1) + sq_bit;
      end else begin
        root = root >> 1;
      end
      sq_bit = sq_bit >> 2;
    end
    return root;
  endfunction

  function automatic rot_res_t rotate_vec(vec_item_t it);
    rot_res_t res;
    longint r [3][3];
    longint v [3];
    longint cx, cy, cz, dx, dy, sn, cs, m, hi, lo, acc, e, vh, vl;
    longint c [3];
    longint u [3];
    longint unsigned mag [3];
    longint unsigned mx, len;
    logic [31:0] a;
    logic neg;
    res = '{x: '0, y: '0, z: '0, err: 1'b0};
    a = cur_angle;
    neg = (a[31:30] == 2'b01) || (a[31:30] == 2'b10);
    if (neg) a = a + 32'h80000000;
    cx = 652032874;
    cy = 0;
    cz = longint'($signed(a));
    for (int i = 0; i < 30; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (cz >= 0) begin
        cx = cx - dx; cy = cy + dy; cz = cz - atan_tbl[i];
      end else begin
        cx = cx + dx; cy = cy - dy; cz = cz + atan_tbl[i];
      end
    end
    cs = neg ? -cx : cx;
    sn = neg ? -cy : cy;
    for (int i = 0; i < 3; i++)
      for (int k = 0; k < 3; k++) r[i][k] = 0;
    case (cur_mode)
      avr_pkg::MODE_X: begin
        r[0][0] = 1 << 30; r[1][1] = cs; r[1][2] = -sn; r[2][1] = sn; r[2][2] = cs;
      end
      avr_pkg::MODE_Y: begin
        r[0][0] = cs; r[0][2] = sn; r[1][1] = 1 << 30; r[2][0] = -sn; r[2][2] = cs;
      end
      avr_pkg::MODE_Z: begin
        r[0][0] = cs; r[0][1] = -sn; r[1][0] = sn; r[1][1] = cs; r[2][2] = 1 << 30;
      end
      default: begin
        c[0] = longint'($signed(cur_ax));
        c[1] = longint'($signed(cur_ay));
        c[2] = longint'($signed(cur_az));
        mx = 0;
        for (int i = 0; i < 3; i++) begin
          mag[i] = (c[i] < 0) ? longint'(-c[i]) : c[i];
          if (mag[i] > mx) mx = mag[i];
        end
        if (mx == 0) begin
          res.err = 1'b1;
          return res;
        end
        while (mx < (64'd1 << 30)) begin
          mx = mx << 1;
          for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
        end
        while (mx > (64'd1 << 31)) begin
          mx = mx >> 1;
          for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
        end
        len = isqrt(mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2]);
        for (int i = 0; i < 3; i++) begin
          u[i] = longint'((mag[i] << 30) / len);
          if (c[i] < 0) u[i] = -u[i];
        end
        m = (64'sd1 << 30) - cs;
        r[0][0] = cs + mulq(mulq(u[0], u[0]), m);
        r[0][1] = mulq(mulq(u[0], u[1]), m) + mulq(u[2], sn);
        r[0][2] = mulq(mulq(u[0], u[2]), m) - mulq(u[1], sn);
        r[1][0] = mulq(mulq(u[1], u[0]), m) - mulq(u[2], sn);
        r[1][1] = cs + mulq(mulq(u[1], u[1]), m);
        r[1][2] = mulq(mulq(u[1], u[2]), m) + mulq(u[0], sn);
        r[2][0] = mulq(mulq(u[2], u[0]), m) + mulq(u[1], sn);
        r[2][1] = mulq(mulq(u[2], u[1]), m) - mulq(u[0], sn);
        r[2][2] = cs + mulq(mulq(u[2], u[2]), m);
      end
    endcase
    v[0] = longint'(it.x);
    v[1] = longint'(it.y);
    v[2] = longint'(it.z);
    for (int i = 0; i < 3; i++) begin
      hi = 0;
      lo = 0;
      for (int k = 0; k < 3; k++) begin
        e = it.op ? r[k][i] : r[i][k];
        vh = v[k] >>> 30;
        vl = v[k] - (vh << 30);
        hi = hi + e * vh;
        lo = lo + e * vl;
      end
      acc = hi + (lo >>> 30);
      if (acc > 64'sd2147483647) acc = 64'sd2147483647;
      if (acc < -64'sd2147483648) acc = -64'sd2147483648;
      if (i == 0) res.x = acc[31:0];
      else if (i == 1) res.y = acc[31:0];
      else res.z = acc[31:0];
    end
    return res;
  endfunction

  // Driver: presents queued vectors, with a random gap after each one while idling is on.
  vec_item_t cur_vec;
  int send_gap = 0;
  always @(posedge clk) begin
    logic nv;
    if (rst) begin
      vin.valid <= 1'b0;
      send_gap <= 0;
    end else begin
      nv = vin.valid;
      if (vin.valid && vin.ready) begin
        expected_rots.push_back(rotate_vec(cur_vec));
        nv = 1'b0;
      end
      if (!nv) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
        end else if (pending_vecs.size() > 0) begin
          cur_vec = pending_vecs.pop_front();
          vin.op <= cur_vec.op;
          vin.vec_x <= cur_vec.x;
          vin.vec_y <= cur_vec.y;
          vin.vec_z <= cur_vec.z;
          nv = 1'b1;
          send_gap <= idle_on ? $urandom_range(0, 8) : 0;
        end
      end
      vin.valid <= nv;
    end
  end

  // Monitor: compares each result transaction with the oldest prediction.
  int stall = 0;
  always @(posedge clk) begin
    rot_res_t want;
    int draw;
    if (rst) begin
      vout.ready <= 1'b0;
      stall <= 0;
    end else begin
      if (vout.valid && vout.ready) begin
        if (expected_rots.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: x=%h y=%h z=%h err=%b",
                     vout.out_x, vout.out_y, vout.out_z, vout.axis_error);
        end else begin
          want = expected_rots.pop_front();
          if (want.x !== vout.out_x || want.y !== vout.out_y ||
              want.z !== vout.out_z || want.err !== vout.axis_error) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected x=%h y=%h z=%h err=%b, got x=%h y=%h z=%h err=%b",
                       want.x, want.y, want.z, want.err,
                       vout.out_x, vout.out_y, vout.out_z, vout.axis_error);
          end
        end
        draw = idle_on ? $urandom_range(0, 8) : 0;
        stall <= draw;
        vout.ready <= (draw == 0);
      end else if (stall > 0) begin
        stall <= stall - 1;
        vout.ready <= (stall == 1);
      end else begin
        vout.ready <= 1'b1;
      end
    end
  end

  task automatic write_reg(logic [avr_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      avr_pkg::REG_AXIS_MODE:      cur_mode = val[1:0];
      avr_pkg::REG_ROTATION_ANGLE: cur_angle = val;
      avr_pkg::REG_AXIS_X:         cur_ax = val;
      avr_pkg::REG_AXIS_Y:         cur_ay = val;
      avr_pkg::REG_AXIS_Z:         cur_az = val;
      default: ;
    endcase
  endtask

  task automatic end_writes();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return $urandom_range(0, 1) ? 32'($urandom_range(0, 1 << 20)) :
                                       -32'($urandom_range(0, 1 << 20));
      3: return 32'h00010000;
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_vec(logic op, logic [31:0] x, logic [31:0] y, logic [31:0] z);
    vec_item_t it;
    it.op = op; it.x = x; it.y = y; it.z = z;
    pending_vecs.push_back(it);
  endtask

  task automatic queue_random(int n);
    for (int i = 0; i < n; i++)
      queue_vec($urandom_range(0, 1), rand_coord(), rand_coord(), rand_coord());
  endtask

  // Lets every queued vector drain, then waits out the pipeline.
  task automatic drain();
    while (pending_vecs.size() > 0 || vin.valid || expected_rots.size() > 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic directed_vecs();
    for (int op = 0; op < 2; op++) begin
      queue_vec(op, 32'h0, 32'h0, 32'h0);
      queue_vec(op, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
      queue_vec(op, 32'h80000000, 32'h80000000, 32'h80000000);
      queue_vec(op, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
      queue_vec(op, 32'h00010000, 32'h0, 32'h0);
      queue_vec(op, 32'h0, 32'h00010000, 32'h0);
      queue_vec(op, 32'h0, 32'h0, 32'h00010000);
      queue_vec(op, 32'hFFFFFFFF, 32'h1, 32'hFFFF0000);
    end
  endtask

  initial begin
    logic [31:0] angles [6];
    atan_tbl = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
      32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
      32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
      32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001};
    angles = '{32'h0, 32'h40000000, 32'h80000000, 32'hC0000000, 32'hFFFFFFFF, 32'h2AAAAAAB};
    vin.valid = 1'b0; vin.op = 1'b0; vin.vec_x = '0; vin.vec_y = '0; vin.vec_z = '0;
    vout.ready = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Settings after reset: z axis, zero angle.
    directed_vecs();
    drain();

    // Axis rotations at angles from a fixed list, including the quadrant boundaries.
    for (int md = 0; md < 3; md++) begin
      write_reg(avr_pkg::REG_AXIS_MODE, md);
      write_reg(avr_pkg::REG_ROTATION_ANGLE, angles[$urandom_range(0, 5)]);
      end_writes();
      queue_random(60);
      drain();
    end

    // Zero-length arbitrary axis raises the error flag.
    write_reg(avr_pkg::REG_AXIS_MODE, avr_pkg::MODE_ARB);
    write_reg(avr_pkg::REG_AXIS_X, 0);
    write_reg(avr_pkg::REG_AXIS_Y, 0);
    write_reg(avr_pkg::REG_AXIS_Z, 0);
    write_reg(3'd7, $urandom);
    end_writes();
    queue_random(20);
    drain();

    // Arbitrary axes with extreme components.
    write_reg(avr_pkg::REG_AXIS_X, 32'h80000000);
    write_reg(avr_pkg::REG_AXIS_Y, 32'h7FFFFFFF);
    write_reg(avr_pkg::REG_AXIS_Z, 32'h80000000);
    write_reg(avr_pkg::REG_ROTATION_ANGLE, 32'hFFFFFFFF);
    end_writes();
    queue_random(40);
    drain();
    write_reg(avr_pkg::REG_AXIS_X, 32'h1);
    write_reg(avr_pkg::REG_AXIS_Y, 32'h0);
    write_reg(avr_pkg::REG_AXIS_Z, 32'h0);
    write_reg(avr_pkg::REG_ROTATION_ANGLE, 32'h40000000);
    end_writes();
    queue_random(40);
    drain();

    // Random settings; some phases run without any idling.
    for (int ph = 0; ph < 26; ph++) begin
      idle_on = ($urandom_range(0, 3) != 0);
      write_reg(avr_pkg::REG_AXIS_MODE,
                $urandom_range(0, 4) == 0 ? $urandom_range(0, 2) : avr_pkg::MODE_ARB);
      write_reg(avr_pkg::REG_ROTATION_ANGLE,
                $urandom_range(0, 2) == 0 ? angles[$urandom_range(0, 5)] : $urandom);
      write_reg(avr_pkg::REG_AXIS_X, $urandom_range(0, 3) == 0 ? 32'h0 : rand_coord());
      write_reg(avr_pkg::REG_AXIS_Y, $urandom_range(0, 3) == 0 ? 32'h0 : rand_coord());
      write_reg(avr_pkg::REG_AXIS_Z, rand_coord());
      end_writes();
      queue_random(50);
      drain();
    end

    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

### axis_angle_vector_rotation_top.f
+incdir+design
design/avr_pkg.sv
design/avr_in_if.sv
design/avr_out_if.sv
design/avr_matrix.sv
design/axis_angle_vector_rotation_top.sv
bench/axis_angle_vector_rotation_top_tb.sv
